### hdl/sknk_pkg.sv
// Package for the sector knock handshake detector.
// Holds the item types, access and action codes, size constants and the knock table.
// No dependencies.
package sknk_pkg;

  // Sizes of one disk block and of the request header within it.
  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned KNOCK_LEN    = 5;

  // Widths of the result fields.
  localparam int unsigned LEN_W = 10;
  localparam int unsigned OFF_W = 4;

  // Reset value of the special LBA register.
  localparam logic [31:0] SPECIAL_LBA_RST = 32'h007F_FFFF;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Block actions.
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_HANDSHAKE = 2'd1;
  localparam logic [1:0] ACT_HREAD     = 2'd2;
  localparam logic [1:0] ACT_HWRITE    = 2'd3;

  // Lengths written in the tag reply header.
  localparam logic [3:0] REPLY_LEN_KNOCK     = 4'd0;
  localparam logic [3:0] REPLY_LEN_HANDSHAKE = 4'd8;

  // Payload placement for handler accesses.
  localparam logic [OFF_W-1:0] OFF_TAGS   = '0;
  localparam logic [OFF_W-1:0] OFF_HEADER = OFF_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] READ_LEN   = LEN_W'(BLOCK_BYTES - HEADER_BYTES);
  localparam logic [15:0]      ROOM_TAGS  = 16'(BLOCK_BYTES);
  localparam logic [15:0]      ROOM_BLOCK = 16'(BLOCK_BYTES - HEADER_BYTES);

  // One snooped sector access.
  typedef struct packed {
    logic        command;
    logic [7:0]  drive;
    logic [31:0] sector;
    logic        tag_request_ok;
    logic [15:0] tag_length;
    logic        block_request_ok;
    logic [15:0] block_length;
    logic        block_all_magic;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic             handled;
    logic             tag_reply;
    logic [3:0]       tag_reply_len;
    logic [1:0]       block_action;
    logic [OFF_W-1:0] payload_offset;
    logic [LEN_W-1:0] payload_len;
    logic [31:0]      reply_sector;
  } out_item_t;

  // Sector expected at each position of the knock sequence.
  function automatic logic [31:0] knock_sector(input logic [2:0] idx);
    logic [31:0] s;
    case (idx)
      3'd0:    s = 32'd0;
      3'd1:    s = 32'd70;
      3'd2:    s = 32'd85;
      3'd3:    s = 32'd74;
      3'd4:    s = 32'd73;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

endpackage

### hdl/sknk_in_reg.sv
// Input register of the sector knock handshake detector.
// Captures one access item and holds it until the decision stage takes it.
// Depends on sknk_pkg.
module sknk_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sknk_pkg::in_item_t in_item,
  output logic               valid_o,
  output sknk_pkg::in_item_t item_o,
  input  logic               take_i
);

  logic               valid_r;
  logic               valid_nxt;
  sknk_pkg::in_item_t item_r;

  // The register is free when empty or when its item moves on this cycle.
  assign in_ready  = !valid_r || take_i;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

### hdl/sknk_core.sv
// Decision logic and handshake state of the sector knock handshake detector.
// Judges one access per cycle while the result side can take it, and updates the knock and handshake state.
// Depends on sknk_pkg.
module sknk_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  sknk_pkg::in_item_t  item_i,
  input  logic                step_i,
  output sknk_pkg::out_item_t result_o
);

  typedef enum logic [1:0] {
    PH_KNOCK  = 2'd0,
    PH_WRITE  = 2'd1,
    PH_READ   = 2'd2,
    PH_SECTOR = 2'd3
  } phase_t;

  logic [31:0] special_lba_r;
  logic [2:0]  knock_index_r, knock_index_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  chosen_drive_r, chosen_drive_nxt;
  logic [31:0] chosen_sector_r, chosen_sector_nxt;

  logic                        is_special;
  logic                        knock_hit;
  logic                        knock_done;
  phase_t                      phase_mid;
  logic [7:0]                  drive_mid;
  logic [31:0]                 sector_mid;
  logic                        h_ok;
  logic [1:0]                  h_act;
  logic [sknk_pkg::OFF_W-1:0]  h_off;
  logic [sknk_pkg::LEN_W-1:0]  h_len;
  logic [15:0]                 w_len;
  logic [15:0]                 w_room;
  logic                        same_target;
  sknk_pkg::out_item_t         res;

  // Handler call: reads take the fixed payload, writes clamp their length.
  always_comb begin
    h_ok   = 1'b1;
    h_act  = sknk_pkg::ACT_HWRITE;
    h_off  = sknk_pkg::OFF_TAGS;
    w_len  = item_i.tag_length;
    w_room = sknk_pkg::ROOM_TAGS;
    h_len  = '0;
    if (item_i.command == sknk_pkg::CMD_READ) begin
      h_act = sknk_pkg::ACT_HREAD;
      h_off = sknk_pkg::OFF_HEADER;
      h_len = sknk_pkg::READ_LEN;
    end else begin
      if (item_i.tag_request_ok) begin
        h_off  = sknk_pkg::OFF_TAGS;
        w_len  = item_i.tag_length;
        w_room = sknk_pkg::ROOM_TAGS;
      end else if (item_i.block_request_ok) begin
        h_off  = sknk_pkg::OFF_HEADER;
        w_len  = item_i.block_length;
        w_room = sknk_pkg::ROOM_BLOCK;
      end else begin
        h_ok  = 1'b0;
        h_act = sknk_pkg::ACT_NONE;
      end
      h_len = (w_len > w_room) ? w_room[sknk_pkg::LEN_W-1:0] : w_len[sknk_pkg::LEN_W-1:0];
    end
  end

  // Knock sequence tracking; an index past the end counts as a mismatch.
  assign is_special = (item_i.sector == special_lba_r);
  assign knock_hit  = (knock_index_r < 3'(sknk_pkg::KNOCK_LEN)) &&
                      (item_i.sector == sknk_pkg::knock_sector(knock_index_r));
  assign knock_done = knock_hit && (knock_index_r == 3'(sknk_pkg::KNOCK_LEN - 1));

  // State as seen after the knock check, before the phase is judged.
  assign phase_mid  = knock_done ? PH_WRITE : phase_r;
  assign drive_mid  = knock_done ? item_i.drive : chosen_drive_r;
  assign sector_mid = knock_done ? 32'd0 : chosen_sector_r;
  assign same_target = (item_i.drive == drive_mid) && (item_i.sector == sector_mid);

  // Result and next state for the current item.
  always_comb begin
    res               = '0;
    knock_index_nxt   = knock_index_r;
    phase_nxt         = phase_r;
    chosen_drive_nxt  = chosen_drive_r;
    chosen_sector_nxt = chosen_sector_r;
    if (is_special) begin
      res.handled      = 1'b1;
      res.block_action = h_act;
      if (h_ok) begin
        res.payload_offset = h_off;
        res.payload_len    = h_len;
      end
      if (phase_r != PH_SECTOR) begin
        phase_nxt = PH_KNOCK;
      end
    end else begin
      knock_index_nxt   = knock_done ? 3'd0 : (knock_hit ? knock_index_r + 3'd1 : 3'd0);
      phase_nxt         = phase_mid;
      chosen_drive_nxt  = drive_mid;
      chosen_sector_nxt = sector_mid;
      if (knock_done) begin
        res.tag_reply     = 1'b1;
        res.tag_reply_len = sknk_pkg::REPLY_LEN_KNOCK;
      end
      case (phase_mid)
        PH_WRITE: begin
          if (item_i.command == sknk_pkg::CMD_WRITE && item_i.drive == drive_mid &&
              item_i.block_all_magic) begin
            chosen_sector_nxt = item_i.sector;
            phase_nxt         = PH_READ;
            res.handled       = 1'b1;
          end
        end
        PH_READ: begin
          if (item_i.command == sknk_pkg::CMD_READ && same_target) begin
            res.tag_reply     = 1'b1;
            res.tag_reply_len = sknk_pkg::REPLY_LEN_HANDSHAKE;
            res.block_action  = sknk_pkg::ACT_HANDSHAKE;
            res.reply_sector  = sector_mid;
            phase_nxt         = PH_SECTOR;
            res.handled       = 1'b1;
          end
        end
        PH_SECTOR: begin
          if (same_target && h_ok) begin
            res.handled        = 1'b1;
            res.block_action   = h_act;
            res.payload_offset = h_off;
            res.payload_len    = h_len;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake state advances only when an item passes through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_lba_r   <= sknk_pkg::SPECIAL_LBA_RST;
      knock_index_r   <= 3'd0;
      phase_r         <= PH_KNOCK;
      chosen_drive_r  <= 8'd0;
      chosen_sector_r <= 32'd0;
    end else begin
      if (cfg_wr_en) begin
        special_lba_r <= cfg_wr_data;
      end
      if (step_i) begin
        knock_index_r   <= knock_index_nxt;
        phase_r         <= phase_nxt;
        chosen_drive_r  <= chosen_drive_nxt;
        chosen_sector_r <= chosen_sector_nxt;
      end
    end
  end

  assign result_o = res;

endmodule

### hdl/sknk_out_reg.sv
// Result register of the sector knock handshake detector.
// Holds one result item until the downstream side takes it.
// Depends on sknk_pkg.
module sknk_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  sknk_pkg::out_item_t item_i,
  output logic                can_take_o,
  output logic                out_valid,
  input  logic                out_ready,
  output sknk_pkg::out_item_t out_item
);

  logic                valid_r;
  logic                valid_nxt;
  sknk_pkg::out_item_t item_r;

  // A new result may enter when the register is empty or being drained.
  assign can_take_o = !valid_r || out_ready;
  assign valid_nxt  = load_i || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_i) begin
      item_r <= item_i;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### hdl/sector_knock_handshake_detector.sv
// Sector knock handshake detector: top level with stream ports and the special LBA register.
// Depends on sknk_pkg, sknk_in_reg, sknk_core and sknk_out_reg.
//
// The block takes one snooped sector access per clock while the output is not stalled and
// gives one result for each via the input and result registers. The rate of one item per cycle
// is set by the single decision stage between the input register and the result register,
// which judges the access and updates the knock and handshake state in the same cycle.
// Back-pressure on the result side reaches in_tready in the same cycle. special_lba is
// written through cfg_wr_en and cfg_wr_data and should only change while the block is idle.
module sector_knock_handshake_detector (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: special LBA register.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Access items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // drive, sector, tag_request_ok, tag_length,
                                 // block_request_ok, block_length, block_all_magic, zero pad
  input  logic        in_tuser,  // command
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // handled, tag_reply, tag_reply_len, payload_offset,
                                 // payload_len, reply_sector, zero pad
  output logic [1:0]  out_tuser  // block_action
);

  sknk_pkg::in_item_t  in_item;
  sknk_pkg::in_item_t  stage_item;
  sknk_pkg::out_item_t core_res;
  sknk_pkg::out_item_t out_item;
  logic                stage_valid;
  logic                out_can_take;
  logic                step;

  // Unpack the input stream.
  always_comb begin
    in_item.command          = in_tuser;
    in_item.drive            = in_tdata[7:0];
    in_item.sector           = in_tdata[39:8];
    in_item.tag_request_ok   = in_tdata[40];
    in_item.tag_length       = in_tdata[56:41];
    in_item.block_request_ok = in_tdata[57];
    in_item.block_length     = in_tdata[73:58];
    in_item.block_all_magic  = in_tdata[74];
  end

  // An item moves from the input register into the result register.
  assign step = stage_valid && out_can_take;

  sknk_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .valid_o  (stage_valid),
    .item_o   (stage_item),
    .take_i   (step)
  );

  sknk_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_i      (stage_item),
    .step_i      (step),
    .result_o    (core_res)
  );

  sknk_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (step),
    .item_i     (core_res),
    .can_take_o (out_can_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item)
  );

  // Pack the result stream.
  assign out_tdata = {4'd0,
                      out_item.reply_sector,
                      out_item.payload_len,
                      out_item.payload_offset,
                      out_item.tag_reply_len,
                      out_item.tag_reply,
                      out_item.handled};
  assign out_tuser = out_item.block_action;

endmodule
